// ----- design/counter_priority_task_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the counter/priority task scheduler
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
`define CPTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");
`define CPTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");
`else
`define CPTS_ASSERT_IMP(lbl, ante, cons)
`define CPTS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- design/cpts_pkg.sv -----
// ----------------------------------------------------------------------------
// cpts_pkg
// Operation codes, field widths and reset constants of the task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int PRIO_W     = 6;
    localparam int INIT_W     = 7;
    localparam int TICK_W     = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam logic [FUNC_W-1:0] OP_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_SET_RUN = 2'd2;
    localparam logic [FUNC_W-1:0] OP_RESCHED = 2'd3;

    localparam int RST_FIELD = 15;

endpackage

`default_nettype wire

// ----- design/cpts_ram.sv -----
// ----------------------------------------------------------------------------
// cpts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/cpts_table.sv -----
// ----------------------------------------------------------------------------
// cpts_table
// Task slot table: RAM of slot entries plus written bits; an entry never
// written reads back as its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_table #(
    parameter int NUM_TASKS     = 64,
    parameter int PRIORITY_BITS = 6
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [$clog2(NUM_TASKS)-1:0]           rd_addr,
    output logic      [2*PRIORITY_BITS+2:0]             rd_data,
    input  wire logic                                   wr_en,
    input  wire logic [$clog2(NUM_TASKS)-1:0]           wr_addr,
    input  wire logic [2*PRIORITY_BITS+2:0]             wr_data
);

    import cpts_pkg::*;

    localparam int PB = PRIORITY_BITS;
    localparam int CB = PRIORITY_BITS + 1;
    localparam int EW = 2 + PB + CB;
    localparam int SW = $clog2(NUM_TASKS);

    logic [NUM_TASKS-1:0] valid_reg;
    logic [NUM_TASKS-1:0] valid_next;
    logic                 rd_valid_reg;
    logic                 rd_zero_reg;
    logic [EW-1:0]        ram_q;
    logic [EW-1:0]        rst_entry;

    cpts_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TASKS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[rd_addr];
        rd_zero_reg  <= (rd_addr == SW'(0));
    end

    assign rst_entry = {rd_zero_reg, rd_zero_reg, PB'(RST_FIELD), CB'(RST_FIELD)};
    assign rd_data   = rd_valid_reg ? ram_q : rst_entry;

endmodule

`default_nettype wire

// ----- design/counter_priority_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Counter/priority task selector over a RAM-held table of task slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready with the operation in s_tuser
//   (tick, load slot, set run flag, reschedule) and the slot fields in
//   s_tdata. Every input word yields exactly one output word on
//   m_tvalid/m_tready carrying the running slot, the switched and
//   recomputed flags and the tick count.
//   One word is worked at a time. A load writes its slot from the
//   execute state; a tick or run-flag write reads the slot there and
//   writes it back in the state after. A reschedule walks the slot RAM
//   one entry a cycle, from the top slot down to slot 1, and a second
//   pass when counters are recomputed reads, updates and writes back
//   each counter. The slot RAM has a single read port.
//   Reset restores the slot table to its reset values at once through
//   written bits: no clearing pass is needed.
//   A stalled output holds its word; the next input word is still taken and
//   worked, and its result waits until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "counter_priority_task_scheduler_macros.svh"

module counter_priority_task_scheduler #(
    parameter int NUM_TASKS     = 64,
    parameter int PRIORITY_BITS = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // slot[5:0], present[6], priority_req[12:7], initial_count[19:13], runnable[20]
    input  wire logic [cpts_pkg::IN_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  wire logic [cpts_pkg::FUNC_W-1:0]        s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // current_task[5:0], switched[6], recomputed[7], tick_count[39:8]
    output logic      [cpts_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import cpts_pkg::*;

    localparam int PB = PRIORITY_BITS;
    localparam int CB = PRIORITY_BITS + 1;
    localparam int EW = 2 + PB + CB;
    localparam int SW = $clog2(NUM_TASKS);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_TICK     = 3'd2;
    localparam logic [2:0] S_RUN      = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_SCAN_END = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [FUNC_W-1:0]      op_reg, op_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   pres_reg, pres_next;
    logic [PRIO_W-1:0]      prio_reg, prio_next;
    logic [INIT_W-1:0]      init_reg, init_next;
    logic                   run_reg, run_next;
    logic [SW-1:0]          running_reg, running_next;
    logic [TICK_W-1:0]      ticks_reg, ticks_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic [SW-1:0]          pipe_addr_reg, pipe_addr_next;
    logic                   pipe_v_reg, pipe_v_next;
    logic                   pass_reg, pass_next;
    logic                   found_reg, found_next;
    logic [SW-1:0]          best_reg, best_next;
    logic [CB-1:0]          best_cnt_reg, best_cnt_next;
    logic                   sw_reg, sw_next;
    logic                   recomp_reg, recomp_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [SW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic          e_pres;
    logic          e_run;
    logic [PB-1:0] e_prio;
    logic [CB-1:0] e_cnt;
    logic [CB-1:0] cnt_dec;
    logic [CB-1:0] cnt_recomp;
    logic [CB-1:0] cand_cnt;
    logic          take;
    logic          found_upd;
    logic [SW-1:0] best_upd;
    logic [CB-1:0] best_cnt_upd;
    logic          slot_ok;
    logic [SW-1:0] slot_addr;
    logic          accept;
    logic          out_free;

    cpts_table #(
        .NUM_TASKS     (NUM_TASKS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    assign slot_ok   = ({{(32-SLOT_W){1'b0}}, slot_reg} < 32'(NUM_TASKS));
    assign slot_addr = SW'(slot_reg);

    assign e_cnt  = rd_data[CB-1:0];
    assign e_prio = rd_data[CB+PB-1:CB];
    assign e_run  = rd_data[CB+PB];
    assign e_pres = rd_data[CB+PB+1];

    assign cnt_dec    = (e_cnt == '0) ? '0 : e_cnt - CB'(1);
    assign cnt_recomp = CB'(e_cnt[CB-1:1]) + CB'(e_prio);
    assign cand_cnt   = pass_reg ? cnt_recomp : e_cnt;
    assign take       = pipe_v_reg && e_pres && e_run
                        && (!found_reg || (cand_cnt > best_cnt_reg));
    assign found_upd    = found_reg || take;
    assign best_upd     = take ? pipe_addr_reg : best_reg;
    assign best_cnt_upd = take ? cand_cnt : best_cnt_reg;

    always_comb
    begin
        case (state_reg)
            S_EXEC:  rd_addr = (op_reg == OP_TICK) ? running_reg : slot_addr;
            S_SCAN:  rd_addr = idx_reg;
            default: rd_addr = running_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        pres_next     = pres_reg;
        prio_next     = prio_reg;
        init_next     = init_reg;
        run_next      = run_reg;
        running_next  = running_reg;
        ticks_next    = ticks_reg;
        idx_next      = idx_reg;
        pipe_addr_next = pipe_addr_reg;
        pipe_v_next   = pipe_v_reg;
        pass_next     = pass_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        sw_next       = sw_reg;
        recomp_next   = recomp_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_addr       = running_reg;
        wr_data       = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = s_tuser;
                    slot_next   = s_tdata[5:0];
                    pres_next   = s_tdata[6];
                    prio_next   = s_tdata[12:7];
                    init_next   = s_tdata[19:13];
                    run_next    = s_tdata[20];
                    sw_next     = 1'b0;
                    recomp_next = 1'b0;
                    if (s_tuser == OP_TICK)
                    begin
                        ticks_next = ticks_reg + TICK_W'(1);
                    end
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_TICK:
                    begin
                        state_next = S_TICK;
                    end
                    OP_LOAD:
                    begin
                        if (slot_ok)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = slot_addr;
                            wr_data = {pres_reg, run_reg, PB'(prio_reg), CB'(init_reg)};
                        end
                        state_next = S_DONE;
                    end
                    OP_SET_RUN:
                    begin
                        state_next = slot_ok ? S_RUN : S_DONE;
                    end
                    default:
                    begin
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_TICK:
            begin
                wr_en      = 1'b1;
                wr_addr    = running_reg;
                wr_data    = {e_pres, e_run, e_prio, cnt_dec};
                state_next = (cnt_dec == '0) ? S_SCAN : S_DONE;
            end
            S_RUN:
            begin
                wr_en      = 1'b1;
                wr_addr    = slot_addr;
                wr_data    = {e_pres, run_reg, e_prio, e_cnt};
                state_next = (!run_reg && (slot_addr == running_reg)) ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                // recompute pass: write back the updated counter one behind the read
                if (pass_reg && pipe_v_reg && e_pres)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pipe_addr_reg;
                    wr_data = {e_pres, e_run, e_prio, cnt_recomp};
                end
                found_next     = found_upd;
                best_next      = best_upd;
                best_cnt_next  = best_cnt_upd;
                pipe_v_next    = 1'b1;
                pipe_addr_next = idx_reg;
                idx_next       = idx_reg - SW'(1);
                if (idx_reg == SW'(1))
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                if (pass_reg && pipe_v_reg && e_pres)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pipe_addr_reg;
                    wr_data = {e_pres, e_run, e_prio, cnt_recomp};
                end
                pipe_v_next = 1'b0;
                if (!pass_reg && found_upd && (best_cnt_upd == '0))
                begin
                    pass_next     = 1'b1;
                    found_next    = 1'b0;
                    best_next     = '0;
                    best_cnt_next = '0;
                    idx_next      = SW'(NUM_TASKS - 1);
                    state_next    = S_SCAN;
                end
                else
                begin
                    running_next = found_upd ? best_upd : '0;
                    sw_next      = 1'b1;
                    recomp_next  = pass_reg;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {ticks_reg, recomp_reg, sw_reg, SLOT_W'(running_reg)};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // arm a fresh scan on entry
        if ((state_reg != S_SCAN) && (state_reg != S_SCAN_END) && (state_next == S_SCAN))
        begin
            pass_next     = 1'b0;
            found_next    = 1'b0;
            best_next     = '0;
            best_cnt_next = '0;
            pipe_v_next   = 1'b0;
            idx_next      = SW'(NUM_TASKS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            running_reg <= '0;
            ticks_reg   <= '0;
            pipe_v_reg  <= 1'b0;
            pass_reg    <= 1'b0;
            found_reg   <= 1'b0;
            sw_reg      <= 1'b0;
            recomp_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            ticks_reg   <= ticks_next;
            pipe_v_reg  <= pipe_v_next;
            pass_reg    <= pass_next;
            found_reg   <= found_next;
            sw_reg      <= sw_next;
            recomp_reg  <= recomp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        slot_reg      <= slot_next;
        pres_reg      <= pres_next;
        prio_reg      <= prio_next;
        init_reg      <= init_next;
        run_reg       <= run_next;
        idx_reg       <= idx_next;
        pipe_addr_reg <= pipe_addr_next;
        best_reg      <= best_next;
        best_cnt_reg  <= best_cnt_next;
        m_data_reg    <= m_data_next;
    end

    `CPTS_ASSERT_NXT(a_busy_after_accept, accept, !s_tready)
    `CPTS_ASSERT_IMP(a_drain_has_data, state_reg == S_SCAN_END, pipe_v_reg)
    `CPTS_ASSERT_IMP(a_scan_skips_slot0,
        ((state_reg == S_SCAN) || (state_reg == S_SCAN_END)) && wr_en, wr_addr != '0)
    `CPTS_ASSERT_IMP(a_recomp_needs_switch, (state_reg == S_DONE) && !sw_reg, !recomp_reg)

endmodule

`default_nettype wire
